### rtl/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg
// Character classes, character codes and result kinds shared by the
// command line tokenizer modules.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned CH_BITS    = 8;
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned CLS_BITS   = 3;

  localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_BITS-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_QUOTE = 8'h22;
  localparam logic [CH_BITS-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CH_BITS-1:0] CH_BSL   = 8'h5C;
  localparam logic [CH_BITS-1:0] CH_UNDER = 8'h5F;

  typedef enum logic [CLS_BITS-1:0] {
    CLS_ZERO   = 3'd0,
    CLS_SPACE  = 3'd1,
    CLS_NL     = 3'd2,
    CLS_SEMI   = 3'd3,
    CLS_QUOTE  = 3'd4,
    CLS_BSL    = 3'd5,
    CLS_NAME   = 3'd6,
    CLS_OTHER  = 3'd7
  } chr_class_t;

  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_ERR = 1'b1;

  function automatic chr_class_t classify(input logic [CH_BITS-1:0] c);
    chr_class_t k;
    if (c == CH_NUL) begin
      k = CLS_ZERO;
    end else if (c == CH_SPACE) begin
      k = CLS_SPACE;
    end else if (c == CH_NL) begin
      k = CLS_NL;
    end else if (c == CH_SEMI) begin
      k = CLS_SEMI;
    end else if (c == CH_QUOTE) begin
      k = CLS_QUOTE;
    end else if (c == CH_BSL) begin
      k = CLS_BSL;
    end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER) begin
      k = CLS_NAME;
    end else begin
      k = CLS_OTHER;
    end
    return k;
  endfunction

endpackage

### rtl/clt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_front
// Accepts characters, classifies them and tags each with its saturating
// offset within the text.
// ----------------------------------------------------------------------------
module clt_front #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [clt_pkg::CH_BITS-1:0]   in_tdata,
  output logic                          push,
  output logic [POSITION_BITS+clt_pkg::CLS_BITS-1:0] push_data,
  input  logic                          fifo_full
);

  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  clt_pkg::chr_class_t      cls;

  assign cls       = clt_pkg::classify(in_tdata);
  assign in_tready = !fifo_full;
  assign push      = in_tvalid && in_tready;
  assign push_data = {pos_r, cls};

  always_comb begin
    if (cls == clt_pkg::CLS_ZERO) begin
      pos_nxt = '0;
    end else if (pos_r == '1) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### rtl/clt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_fifo
// Short queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module clt_fifo #(
  parameter int unsigned WIDTH      = 19,
  parameter int unsigned DEPTH_LOG2 = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr_r;
  logic [DEPTH_LOG2-1:0] rd_ptr_r;
  logic [DEPTH_LOG2:0]   count_r;
  logic [DEPTH_LOG2:0]   count_nxt;

  assign full      = (count_r == (DEPTH_LOG2+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/clt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_back
// Parser state machine over classified characters, with the result register.
// ----------------------------------------------------------------------------
module clt_back #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  logic [POSITION_BITS+clt_pkg::CLS_BITS-1:0] item_data,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [4*clt_pkg::FIELD_BITS-1:0] out_tdata,
  output logic                          out_tuser
);

  typedef enum logic [2:0] {
    M_SKIP, M_NAME, M_SPACES, M_ARGS, M_QUOTE, M_ESC, M_IGNORE
  } mode_t;

  typedef logic [POSITION_BITS-1:0] pos_t;
  localparam int unsigned FB = clt_pkg::FIELD_BITS;

  mode_t               mode_r, mode_nxt;
  pos_t                name_start_r, name_start_nxt;
  pos_t                name_len_r, name_len_nxt;
  pos_t                args_start_r, args_start_nxt;
  pos_t                args_end_r, args_end_nxt;
  logic                out_valid_r;
  logic [4*FB-1:0]     out_data_r, out_data_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic                emit;
  clt_pkg::chr_class_t cls;
  pos_t                p;

  function automatic logic [FB-1:0] clampf(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd65535) ? {FB{1'b1}} : w[FB-1:0];
  endfunction

  function automatic pos_t sat_next(input pos_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign cls        = clt_pkg::chr_class_t'(item_data[clt_pkg::CLS_BITS-1:0]);
  assign p          = item_data[POSITION_BITS+clt_pkg::CLS_BITS-1:clt_pkg::CLS_BITS];
  assign pop        = item_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    logic go;
    logic quote_path;
    pos_t len;
    mode_nxt       = mode_r;
    name_start_nxt = name_start_r;
    name_len_nxt   = name_len_r;
    args_start_nxt = args_start_r;
    args_end_nxt   = args_end_r;
    emit           = 1'b0;
    out_kind_nxt   = clt_pkg::KIND_CMD;
    out_data_nxt   = '0;
    go             = 1'b0;
    quote_path     = 1'b0;
    len            = '0;

    unique case (mode_r)
      M_SKIP: begin
        if (cls == clt_pkg::CLS_NAME) begin
          name_start_nxt = p;
          name_len_nxt   = pos_t'(1);
          mode_nxt       = M_NAME;
        end else if (cls == clt_pkg::CLS_OTHER || cls == clt_pkg::CLS_QUOTE ||
                     cls == clt_pkg::CLS_BSL) begin
          emit          = 1'b1;
          out_kind_nxt  = clt_pkg::KIND_ERR;
          out_data_nxt  = {{(3*FB){1'b0}}, clampf(p)};
          mode_nxt      = M_IGNORE;
        end
      end
      M_IGNORE: begin
      end
      M_QUOTE: begin
        quote_path = 1'b1;
      end
      M_ESC: begin
        mode_nxt = M_QUOTE;
        if (cls != clt_pkg::CLS_QUOTE && cls != clt_pkg::CLS_BSL) begin
          quote_path = 1'b1;
        end
      end
      M_NAME: begin
        if (cls == clt_pkg::CLS_NAME) begin
          name_len_nxt = sat_next(name_len_r);
        end else begin
          go = 1'b1;
        end
      end
      M_SPACES: begin
        go = 1'b1;
      end
      M_ARGS: begin
        go = 1'b1;
      end
      default: begin
      end
    endcase

    if (go) begin
      if ((mode_r == M_NAME || mode_r == M_SPACES) && cls == clt_pkg::CLS_SPACE) begin
        mode_nxt = M_SPACES;
      end else begin
        if (mode_r != M_ARGS) begin
          args_start_nxt = p;
          args_end_nxt   = p;
          mode_nxt       = M_ARGS;
        end
        case (cls) inside
          clt_pkg::CLS_QUOTE: begin
            args_end_nxt = sat_next(p);
            mode_nxt     = M_QUOTE;
          end
          clt_pkg::CLS_ZERO, clt_pkg::CLS_SEMI, clt_pkg::CLS_NL: begin
            emit = 1'b1;
          end
          clt_pkg::CLS_SPACE: begin
          end
          default: begin
            args_end_nxt = sat_next(p);
          end
        endcase
      end
    end

    if (quote_path) begin
      case (cls) inside
        clt_pkg::CLS_ZERO, clt_pkg::CLS_NL: begin
          emit = 1'b1;
        end
        clt_pkg::CLS_QUOTE: begin
          args_end_nxt = sat_next(p);
          mode_nxt     = M_ARGS;
        end
        clt_pkg::CLS_SPACE, clt_pkg::CLS_SEMI: begin
        end
        clt_pkg::CLS_BSL: begin
          args_end_nxt = sat_next(p);
          mode_nxt     = M_ESC;
        end
        default: begin
          args_end_nxt = sat_next(p);
        end
      endcase
    end

    if (emit && out_kind_nxt == clt_pkg::KIND_CMD) begin
      len          = (args_end_nxt >= args_start_nxt) ? args_end_nxt - args_start_nxt : '0;
      out_data_nxt = {clampf(len), clampf(args_start_nxt), clampf(name_len_nxt),
                      clampf(name_start_nxt)};
      mode_nxt     = M_SKIP;
    end

    if (cls == clt_pkg::CLS_ZERO) begin
      mode_nxt = M_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_SKIP;
      name_start_r <= '0;
      name_len_r   <= '0;
      args_start_r <= '0;
      args_end_r   <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
      out_kind_r   <= clt_pkg::KIND_CMD;
    end else begin
      if (pop) begin
        mode_r       <= mode_nxt;
        name_start_r <= name_start_nxt;
        name_len_r   <= name_len_nxt;
        args_start_r <= args_start_nxt;
        args_end_r   <= args_end_nxt;
        out_valid_r  <= emit;
        if (emit) begin
          out_data_r <= out_data_nxt;
          out_kind_r <= out_kind_nxt;
        end
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

endmodule

### rtl/command_line_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_top
// Splits a character stream into commands: name and argument spans.
//
//   channel | dir | tdata                                   | tuser
//   in_     | in  | [7:0] ch                                | -
//   out_    | out | [15:0] name_start, [31:16] name_len,    | kind
//           |     | [47:32] args_start, [63:48] args_len    |
//
// One character per cycle sustained while out_tready accepts results; a result is
// on out_ after its closing character transfers (queue write, then parser register).
// While a result waits, the four-entry queue takes up to four more characters
// before in_tready drops.
// Synchronous active-low reset returns the parser to skipping junk at offset 0.
// ----------------------------------------------------------------------------
module command_line_tokenizer_top #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // name_start, name_len, args_start, args_len
  output logic        out_tuser   // kind
);

  localparam int unsigned IW = POSITION_BITS + clt_pkg::CLS_BITS;

  logic          push;
  logic [IW-1:0] push_data;
  logic          fifo_full;
  logic          pop;
  logic          item_valid;
  logic [IW-1:0] item_data;

  clt_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  clt_fifo #(.WIDTH(IW), .DEPTH_LOG2(2)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (item_valid),
    .pop_data  (item_data)
  );

  clt_back #(.POSITION_BITS(POSITION_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_data  (item_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
